[sv/lzwc_pkg.sv]
package lzwc_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int HASH_DEPTH    = 8192;
    localparam int SLOT_W        = $clog2(HASH_DEPTH);
    localparam int TRY_W         = SLOT_W + 1;
    localparam int START_WIDTH   = 9;
    localparam int LITERAL_CODES = 256;
    localparam int BYTE_BITS     = 8;
    localparam int WIDTH_W       = 5;
    localparam int NF_W          = MAX_CODE_BITS + 1;
    localparam int ACC_W         = MAX_CODE_BITS + BYTE_BITS;
    localparam int CNT_W         = 5;
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    typedef logic [MAX_CODE_BITS-1:0] code_t;

    typedef struct packed {
        logic        valid;
        code_t       prefix;
        logic [7:0]  byt;
        code_t       code;
    } dict_entry_t;

    typedef struct packed {
        code_t               code;
        logic [WIDTH_W-1:0]  width;
        logic                pad;
        logic                fin;
    } pack_cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_MISS,
        ST_FLUSH
    } ctrl_state_t;

endpackage

[sv/lzwc_hash.sv]
module lzwc_hash
(
    input  logic                          clk,
    input  logic                          load,
    input  lzwc_pkg::code_t               prefix,
    input  logic [7:0]                    data_byte,
    output logic [lzwc_pkg::SLOT_W-1:0]   slot
);

    logic [31:0] key;
    logic [31:0] mixed;
    logic [31:0] product_reg;
    logic [31:0] product_next;
    logic [31:0] folded;

    always_comb
    begin
        key          = 32'({prefix, data_byte});
        mixed        = key ^ (key >> 11);
        product_next = mixed * lzwc_pkg::HASH_MULT;
        folded       = product_reg ^ (product_reg >> 15);
        slot         = folded[lzwc_pkg::SLOT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= product_next;
        end
    end

endmodule

[sv/lzwc_dict.sv]
module lzwc_dict
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [lzwc_pkg::SLOT_W-1:0]   wr_addr,
    input  lzwc_pkg::dict_entry_t         wr_data,
    input  logic [lzwc_pkg::SLOT_W-1:0]   rd_addr,
    output lzwc_pkg::dict_entry_t         rd_data
);

    lzwc_pkg::dict_entry_t mem [lzwc_pkg::HASH_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[sv/lzwc_packer.sv]
module lzwc_packer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  lzwc_pkg::pack_cmd_t   cmd,
    output logic                  cmd_ready,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  run_end
);

    logic                            busy_reg, busy_next;
    logic                            pad_reg, pad_next;
    logic                            fin_reg, fin_next;
    logic [lzwc_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [lzwc_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic [7:0]                      out_byte_reg, out_byte_next;
    logic                            run_end_reg, run_end_next;

    logic                            slot_free;
    logic [lzwc_pkg::CNT_W-1:0]      cnt_less;
    logic [lzwc_pkg::ACC_W-1:0]      shifted;
    logic [lzwc_pkg::ACC_W-1:0]      keep_mask;
    logic [lzwc_pkg::CNT_W-1:0]      pad_sh;
    logic [7:0]                      pad_byte;
    logic                            done;

    always_comb
    begin
        slot_free = !out_valid_reg || !out_stall;
        cnt_less  = cnt_reg - lzwc_pkg::CNT_W'(lzwc_pkg::BYTE_BITS);
        shifted   = acc_reg >> cnt_less;
        keep_mask = (lzwc_pkg::ACC_W'(1) << cnt_less) - lzwc_pkg::ACC_W'(1);
        pad_sh    = lzwc_pkg::CNT_W'(lzwc_pkg::BYTE_BITS) - cnt_reg;
        pad_byte  = acc_reg[7:0] << pad_sh[2:0];
        done      = 1'b0;

        busy_next      = busy_reg;
        pad_next       = pad_reg;
        fin_next       = fin_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;
        out_byte_next  = out_byte_reg;
        run_end_next   = run_end_reg;

        if (busy_reg)
        begin
            if (slot_free)
            begin
                if (cnt_reg >= lzwc_pkg::CNT_W'(lzwc_pkg::BYTE_BITS))
                begin
                    // last byte of this code unless more whole bytes or a pad byte follow
                    done = (cnt_less < lzwc_pkg::CNT_W'(lzwc_pkg::BYTE_BITS))
                        && !(pad_reg && (cnt_less != '0));
                    out_valid_next = 1'b1;
                    out_byte_next  = shifted[7:0];
                    run_end_next   = fin_reg && done;
                    cnt_next       = cnt_less;
                    acc_next       = acc_reg & keep_mask;
                    busy_next      = !done;
                end
                else if (pad_reg && (cnt_reg != '0))
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pad_byte;
                    run_end_next   = fin_reg;
                    cnt_next       = '0;
                    acc_next       = '0;
                    busy_next      = 1'b0;
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end
        end
        else if (cmd_valid)
        begin
            acc_next  = (acc_reg << cmd.width) | lzwc_pkg::ACC_W'(cmd.code);
            cnt_next  = cnt_reg + lzwc_pkg::CNT_W'(cmd.width);
            pad_next  = cmd.pad;
            fin_next  = cmd.fin;
            busy_next = 1'b1;
        end

        cmd_ready = !busy_reg;
        out_valid = out_valid_reg;
        out_byte  = out_byte_reg;
        run_end   = run_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pad_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pad_reg       <= pad_next;
            fin_reg       <= fin_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        run_end_reg  <= run_end_next;
    end

    a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg < lzwc_pkg::CNT_W'(lzwc_pkg::BYTE_BITS))
        else $error("packer idle with a whole byte left");

    a_cmd_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> !busy_reg)
        else $error("code handed to packer while busy");

endmodule

[sv/lzw_compressor_bit_packer.sv]
// an item is taken only in idle: a dictionary hit passes the hash state and then probes,
// and a miss also waits in the miss state while the packer still drains the previous code
// probing reads one hashed table slot per cycle through the dictionary's own read port
// the packer sends one byte per cycle unless out_stall holds it; each byte is registered
// onto out_byte once its code is in the accumulator; reset, and each item with last_byte,
// clear all 8192 dictionary slots, taking no item; prefix, next code and width restart
module lzw_compressor_bit_packer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_end
);

    lzwc_pkg::ctrl_state_t               state_reg, state_next;
    lzwc_pkg::code_t                     prefix_reg, prefix_next;
    logic                                prefix_valid_reg, prefix_valid_next;
    logic [lzwc_pkg::NF_W-1:0]           next_free_reg, next_free_next;
    logic [lzwc_pkg::WIDTH_W-1:0]        width_reg, width_next;
    logic [7:0]                          byte_reg, byte_next;
    logic                                last_reg, last_next;
    logic [lzwc_pkg::SLOT_W-1:0]         slot_reg, slot_next;
    logic [lzwc_pkg::TRY_W-1:0]          tries_reg, tries_next;
    logic                                free_ok_reg, free_ok_next;
    logic [lzwc_pkg::SLOT_W-1:0]         clr_reg, clr_next;

    logic                                hash_load;
    logic [lzwc_pkg::SLOT_W-1:0]         hash_slot;
    logic                                wr_en;
    logic [lzwc_pkg::SLOT_W-1:0]         wr_addr;
    lzwc_pkg::dict_entry_t               wr_data;
    logic [lzwc_pkg::SLOT_W-1:0]         rd_addr;
    lzwc_pkg::dict_entry_t               rd_data;
    logic                                cmd_valid;
    lzwc_pkg::pack_cmd_t                 cmd;
    logic                                cmd_ready;

    logic [lzwc_pkg::NF_W-1:0]           width_pow;
    logic                                grow;
    logic [lzwc_pkg::WIDTH_W-1:0]        eff_width;
    logic                                match;

    lzwc_hash u_hash
    (
        .clk       (clk),
        .load      (hash_load),
        .prefix    (prefix_reg),
        .data_byte (data_byte),
        .slot      (hash_slot)
    );

    lzwc_dict u_dict
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lzwc_packer u_packer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_end   (run_end)
    );

    always_comb
    begin
        // widen the code once the dictionary outgrows it
        width_pow = lzwc_pkg::NF_W'(1) << width_reg;
        grow      = (width_reg < lzwc_pkg::WIDTH_W'(lzwc_pkg::MAX_CODE_BITS))
                 && (next_free_reg > width_pow);
        eff_width = grow ? width_reg + lzwc_pkg::WIDTH_W'(1) : width_reg;
        match     = (rd_data.prefix == prefix_reg) && (rd_data.byt == byte_reg);

        state_next        = state_reg;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        next_free_next    = next_free_reg;
        width_next        = width_reg;
        byte_next         = byte_reg;
        last_next         = last_reg;
        slot_next         = slot_reg;
        tries_next        = tries_reg;
        free_ok_next      = free_ok_reg;
        clr_next          = clr_reg;

        in_stall  = (state_reg != lzwc_pkg::ST_IDLE);
        hash_load = 1'b0;
        rd_addr   = hash_slot;
        wr_en     = 1'b0;
        wr_addr   = clr_reg;
        wr_data   = '0;
        cmd_valid = 1'b0;
        cmd       = '0;

        unique case (state_reg)
            lzwc_pkg::ST_CLEAR:
            begin
                wr_en    = 1'b1;
                clr_next = clr_reg + lzwc_pkg::SLOT_W'(1);
                if (clr_reg == lzwc_pkg::SLOT_W'(lzwc_pkg::HASH_DEPTH - 1))
                begin
                    state_next = lzwc_pkg::ST_IDLE;
                end
            end
            lzwc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = data_byte;
                    last_next = last_byte;
                    if (!prefix_valid_reg)
                    begin
                        prefix_next       = lzwc_pkg::code_t'(data_byte);
                        prefix_valid_next = 1'b1;
                        if (last_byte)
                        begin
                            state_next = lzwc_pkg::ST_FLUSH;
                        end
                    end
                    else
                    begin
                        hash_load  = 1'b1;
                        state_next = lzwc_pkg::ST_HASH;
                    end
                end
            end
            lzwc_pkg::ST_HASH:
            begin
                rd_addr    = hash_slot;
                slot_next  = hash_slot;
                tries_next = '0;
                state_next = lzwc_pkg::ST_PROBE;
            end
            lzwc_pkg::ST_PROBE:
            begin
                // next slot is read speculatively; data is used only on a collision
                rd_addr = slot_reg + lzwc_pkg::SLOT_W'(1);
                if (!rd_data.valid)
                begin
                    free_ok_next = 1'b1;
                    state_next   = lzwc_pkg::ST_MISS;
                end
                else if (match)
                begin
                    prefix_next = rd_data.code;
                    state_next  = last_reg ? lzwc_pkg::ST_FLUSH : lzwc_pkg::ST_IDLE;
                end
                else
                begin
                    slot_next  = slot_reg + lzwc_pkg::SLOT_W'(1);
                    tries_next = tries_reg + lzwc_pkg::TRY_W'(1);
                    if (tries_reg == lzwc_pkg::TRY_W'(lzwc_pkg::HASH_DEPTH - 1))
                    begin
                        free_ok_next = 1'b0;
                        state_next   = lzwc_pkg::ST_MISS;
                    end
                end
            end
            lzwc_pkg::ST_MISS:
            begin
                if (cmd_ready)
                begin
                    cmd_valid  = 1'b1;
                    cmd.code   = prefix_reg;
                    cmd.width  = eff_width;
                    cmd.pad    = 1'b0;
                    cmd.fin    = !last_reg;
                    width_next = eff_width;
                    if (!next_free_reg[lzwc_pkg::MAX_CODE_BITS] && free_ok_reg)
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = slot_reg;
                        wr_data.valid  = 1'b1;
                        wr_data.prefix = prefix_reg;
                        wr_data.byt    = byte_reg;
                        wr_data.code   = next_free_reg[lzwc_pkg::MAX_CODE_BITS-1:0];
                        next_free_next = next_free_reg + lzwc_pkg::NF_W'(1);
                    end
                    prefix_next = lzwc_pkg::code_t'(byte_reg);
                    state_next  = last_reg ? lzwc_pkg::ST_FLUSH : lzwc_pkg::ST_IDLE;
                end
            end
            lzwc_pkg::ST_FLUSH:
            begin
                if (cmd_ready)
                begin
                    cmd_valid         = 1'b1;
                    cmd.code          = prefix_reg;
                    cmd.width         = eff_width;
                    cmd.pad           = 1'b1;
                    cmd.fin           = 1'b1;
                    prefix_next       = '0;
                    prefix_valid_next = 1'b0;
                    next_free_next    = lzwc_pkg::NF_W'(lzwc_pkg::LITERAL_CODES);
                    width_next        = lzwc_pkg::WIDTH_W'(lzwc_pkg::START_WIDTH);
                    clr_next          = '0;
                    state_next        = lzwc_pkg::ST_CLEAR;
                end
            end
            default:
            begin
                clr_next   = '0;
                state_next = lzwc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lzwc_pkg::ST_CLEAR;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            next_free_reg    <= lzwc_pkg::NF_W'(lzwc_pkg::LITERAL_CODES);
            width_reg        <= lzwc_pkg::WIDTH_W'(lzwc_pkg::START_WIDTH);
            last_reg         <= 1'b0;
            slot_reg         <= '0;
            tries_reg        <= '0;
            free_ok_reg      <= 1'b0;
            clr_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            next_free_reg    <= next_free_next;
            width_reg        <= width_next;
            last_reg         <= last_next;
            slot_reg         <= slot_next;
            tries_reg        <= tries_next;
            free_ok_reg      <= free_ok_next;
            clr_reg          <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    a_probe_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lzwc_pkg::ST_PROBE
            |-> tries_reg < lzwc_pkg::TRY_W'(lzwc_pkg::HASH_DEPTH))
        else $error("probe ran past table depth");

    a_add_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && wr_data.valid |-> !next_free_reg[lzwc_pkg::MAX_CODE_BITS])
        else $error("entry added to full dictionary");

    a_width_capped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> cmd.width <= lzwc_pkg::WIDTH_W'(lzwc_pkg::MAX_CODE_BITS))
        else $error("code width above maximum");

    a_no_write_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lzwc_pkg::ST_PROBE |-> !wr_en)
        else $error("dictionary written during probe");

endmodule

[tb/lzw_compressor_bit_packer_tb.sv]
`timescale 1ns / 100ps

module lzw_compressor_bit_packer_tb;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int PHASE_ITEMS = 67;

    typedef struct {
        logic [7:0] byt;
        logic       fin;
    } packed_out_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         n_known;
        logic [7:0] known [4];
    } stim_row_t;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_stall;
    logic [7:0] data_byte = 0;
    logic       last_byte = 0;
    logic       out_valid;
    logic       out_stall = 0;
    logic [7:0] out_byte;
    logic       run_end;

    int errors = 0;
    int cycles = 0;
    int idle_in = 0;
    int idle_out = 0;

    packed_out_t pending_bytes [$];
    logic [7:0]  step_bytes [$];

    // predictor state
    lzwc_pkg::code_t  pfx;
    logic             pfx_ok;
    int               nfree;
    int               cwidth;
    logic [31:0]      bit_acc;
    int               bit_cnt;
    logic             slot_used [lzwc_pkg::HASH_DEPTH];
    lzwc_pkg::code_t  slot_pfx [lzwc_pkg::HASH_DEPTH];
    logic [7:0]       slot_byte [lzwc_pkg::HASH_DEPTH];
    lzwc_pkg::code_t  slot_code [lzwc_pkg::HASH_DEPTH];

    lzw_compressor_bit_packer dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .run_end(run_end)
    );

    always #4 clk = ~clk;

    task automatic mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    task automatic clear_model();
        pfx = 0;
        pfx_ok = 0;
        nfree = lzwc_pkg::LITERAL_CODES;
        cwidth = lzwc_pkg::START_WIDTH;
        bit_acc = 0;
        bit_cnt = 0;
        for (int i = 0; i < lzwc_pkg::HASH_DEPTH; i++)
        begin
            slot_used[i] = 0;
        end
    endtask

    function automatic int hash_of(lzwc_pkg::code_t p, logic [7:0] b);
        logic [31:0] key;
        key = ({20'd0, p} << 8) | b;
        key = key ^ (key >> 11);
        key = key * 32'd2654435761;
        key = key ^ (key >> 15);
        return int'(key % lzwc_pkg::HASH_DEPTH);
    endfunction

    task automatic pack_code(input lzwc_pkg::code_t c);
        logic [31:0] mask;
        while (cwidth < lzwc_pkg::MAX_CODE_BITS && nfree > (1 << cwidth))
        begin
            cwidth++;
        end
        mask = (32'd1 << cwidth) - 1;
        bit_acc = (bit_acc << cwidth) | (32'(c) & mask);
        bit_cnt += cwidth;
        while (bit_cnt >= lzwc_pkg::BYTE_BITS)
        begin
            bit_cnt -= lzwc_pkg::BYTE_BITS;
            step_bytes = {step_bytes, 8'(bit_acc >> bit_cnt)};
            bit_acc &= (32'd1 << bit_cnt) - 1;
        end
    endtask

    // fills step_bytes with the bytes one input item produces
    task automatic compress_step(input logic [7:0] b, input logic fin);
        int   slot;
        int   free_slot;
        logic hit;
        step_bytes.delete();
        if (!pfx_ok)
        begin
            pfx = lzwc_pkg::code_t'(b);
            pfx_ok = 1;
        end
        else
        begin
            slot = hash_of(pfx, b);
            free_slot = -1;
            hit = 0;
            for (int t = 0; t < lzwc_pkg::HASH_DEPTH; t++)
            begin
                if (!slot_used[slot])
                begin
                    free_slot = slot;
                    break;
                end
                if (slot_pfx[slot] == pfx && slot_byte[slot] == b)
                begin
                    hit = 1;
                    break;
                end
                slot = (slot + 1) % lzwc_pkg::HASH_DEPTH;
            end
            if (hit)
            begin
                pfx = slot_code[slot];
            end
            else
            begin
                pack_code(pfx);
                if (nfree < (1 << lzwc_pkg::MAX_CODE_BITS) && free_slot >= 0)
                begin
                    slot_used[free_slot] = 1;
                    slot_pfx[free_slot] = pfx;
                    slot_byte[free_slot] = b;
                    slot_code[free_slot] = lzwc_pkg::code_t'(nfree);
                    nfree++;
                end
                pfx = lzwc_pkg::code_t'(b);
            end
        end
        if (fin)
        begin
            pack_code(pfx);
            if (bit_cnt > 0)
            begin
                step_bytes = {step_bytes, 8'(bit_acc << (lzwc_pkg::BYTE_BITS - bit_cnt))};
            end
            clear_model();
        end
    endtask

    task automatic queue_bytes(input logic [7:0] bytes [$]);
        packed_out_t r;
        foreach (bytes[i])
        begin
            r.byt = bytes[i];
            r.fin = (i == bytes.size() - 1);
            pending_bytes = {pending_bytes, r};
        end
    endtask

    task automatic drive_item(input logic [7:0] b, input logic fin);
        @(negedge clk);
        while ($urandom_range(99) < idle_in)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        data_byte <= b;
        last_byte <= fin;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
            begin
                break;
            end
        end
    endtask

    task automatic send_checked(input logic [7:0] b, input logic fin);
        drive_item(b, fin);
        compress_step(b, fin);
        queue_bytes(step_bytes);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 0;
        while (pending_bytes.size() > 0)
        begin
            @(negedge clk);
        end
    endtask

    // random run: mostly a small alphabet so prefixes grow, sometimes full-range bytes
    task automatic random_run(input int len);
        logic       narrow;
        logic [7:0] b;
        narrow = ($urandom_range(3) != 0);
        for (int i = 0; i < len; i++)
        begin
            b = narrow ? 8'($urandom_range(3)) + 8'h41 : 8'($urandom_range(255));
            send_checked(b, i == len - 1);
        end
    endtask

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < idle_out);
    end

    always @(posedge clk)
    begin
        packed_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                mismatch($sformatf("unexpected output byte %02h", out_byte));
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.byt)
                begin
                    mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.byt));
                end
                if (run_end !== want.fin)
                begin
                    mismatch($sformatf("run_end %b, expected %b", run_end, want.fin));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d bytes outstanding", pending_bytes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    stim_row_t directed [20] = '{
        '{8'hFF, 1'b1, 2, '{8'h7F, 8'h80, 8'h00, 8'h00}},
        '{8'h00, 1'b1, 2, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h80, 1'b0, 0, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h01, 1'b1, 3, '{8'h40, 8'h00, 8'h40, 8'h00}},
        '{8'h41, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h42, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h41, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h42, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h41, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h42, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h41, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h42, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h00, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h00, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h00, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'hFF, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'hFF, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h55, 1'b0, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'hAA, 1'b1, -1, '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'h7E, 1'b1, -1, '{8'h00, 8'h00, 8'h00, 8'h00}}
    };

    initial
    begin
        logic [7:0] typed [$];
        int         sent;
        clear_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        foreach (directed[i])
        begin
            drive_item(directed[i].data, directed[i].last);
            compress_step(directed[i].data, directed[i].last);
            if (directed[i].n_known >= 0)
            begin
                typed.delete();
                for (int k = 0; k < directed[i].n_known; k++)
                begin
                    typed = {typed, directed[i].known[k]};
                end
                queue_bytes(typed);
            end
            else
            begin
                queue_bytes(step_bytes);
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            wait_drained();
            idle_in = (phase == 0) ? 11 : (phase == 1) ? 64 : 0;
            idle_out = (phase == 0) ? 64 : (phase == 1) ? 11 : 0;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                int len;
                len = $urandom_range(40, 1);
                if (len > PHASE_ITEMS - sent)
                begin
                    len = PHASE_ITEMS - sent;
                end
                random_run(len);
                sent += len;
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[lzw_compressor_bit_packer.f]
sv/lzwc_pkg.sv
sv/lzwc_hash.sv
sv/lzwc_dict.sv
sv/lzwc_packer.sv
sv/lzw_compressor_bit_packer.sv
tb/lzw_compressor_bit_packer_tb.sv
